// ----- src/rit_pkg.sv -----
`default_nettype none

package rit_pkg;

   // Tick field width used by the timer core
   localparam int TICK_BITS_DEF = 8;

   // Register map
   localparam logic [15:0] ADDR_RELOAD_LO = 16'h401B;
   localparam logic [15:0] ADDR_RELOAD_HI = 16'h401C;
   localparam logic [15:0] ADDR_CONTROL   = 16'h401D;

   localparam logic [15:0] RELOAD_RESET = 16'hFFFF;

   // Status byte bits
   localparam logic [7:0] STAT_IRQ    = 8'h80;
   localparam logic [7:0] STAT_ACTIVE = 8'h01;

   // Transaction kind carried on tuser
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_CLOCK = 2'd2
   } opcode_type;

   // Sequencer states
   typedef enum logic [0:0] {
      ST_IDLE   = 1'b0,
      ST_DIVIDE = 1'b1
   } state_type;

   // Handshake between the sequencer and the remainder unit
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

// ----- src/rit_mod.sv -----
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle through a single
// 17-bit compare and subtract.
module rit_mod #(
   parameter int DW = rit_pkg::TICK_BITS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  rit_pkg::div_ctl_type       ctl,
   input  wire  [DW-1:0]              dividend,
   input  wire  [15:0]                divisor,
   output rit_pkg::div_stat_type      stat,
   output logic [15:0]                remainder
);

   localparam int CW = $clog2(DW + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [15:0]   rem_ff, rem_in;
   logic [16:0]   trial;
   logic [16:0]   diff;

   // Shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, dvd_ff[DW-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      if (ctl.start) begin
         count_in = '0;
         busy_in  = 1'b1;
         dvd_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         dvd_in   = dvd_ff << 1;
         rem_in   = (trial >= {1'b0, divisor}) ? diff[15:0] : trial[15:0];
         count_in = count_ff + CW'(1);
         if (count_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- src/reload_irq_timer.sv -----
`default_nettype none

// Bus-mapped 16-bit reload down-counter with an interrupt. Each request
// transaction is a byte read, a byte write or a clock advance (kind on
// req_tuser); each produces exactly one response carrying the hit flag, the
// read byte and the irq level after the transaction. Registers: 0x401B reload
// low, 0x401C reload high, 0x401D control/status (read returns irq in bit 7 and
// active in bit 0 and clears irq; write reloads the counter if idle and sets
// active from bit 0). Reads, writes and clock advances that do not run past
// zero are answered directly from the idle state. An advance that runs past
// zero with a nonzero reload needs the remainder of the excess minus one by
// the reload value; it goes through a bit-serial remainder unit, and no
// request is taken meanwhile.
module reload_irq_timer #(
   parameter int TICK_BITS = rit_pkg::TICK_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   // req_tdata: address[15:0], write_data[23:16], tick_count[31:24]
   input  wire  [31:0] req_tdata,
   // req_tuser: opcode[1:0]
   input  wire  [1:0]  req_tuser,
   input  wire         req_tvalid,
   output logic        req_tready,
   // rsp_tdata: hit[0], read_data[8:1], irq_line[9], zero fill [15:10]
   output logic [15:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready
);

   rit_pkg::state_type  state_ff, state_in;
   logic [15:0]         reload_ff, reload_in;
   logic [15:0]         counter_ff, counter_in;
   logic                enabled_ff, enabled_in;
   logic                irq_ff, irq_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff, rsp_data_in;

   rit_pkg::opcode_type  opcode;
   logic [15:0]          address;
   logic [7:0]           write_data;
   logic [15:0]          tick_wide;
   logic [TICK_BITS-1:0] ticks;
   logic [15:0]          ticks_ext;
   logic [15:0]          rest;
   logic [15:0]          rest_m1;
   logic                 in_range;
   logic                 accept;
   logic                 hit;
   logic [7:0]           rd;

   rit_pkg::div_ctl_type  div_ctl;
   rit_pkg::div_stat_type div_stat;
   logic [15:0]           div_rem;

   // Unpack the request transaction
   assign opcode     = rit_pkg::opcode_type'(req_tuser);
   assign address    = req_tdata[15:0];
   assign write_data = req_tdata[23:16];
   assign tick_wide  = {8'h00, req_tdata[31:24]};
   assign ticks      = tick_wide[TICK_BITS-1:0];
   assign ticks_ext  = 16'(ticks);
   assign rest       = ticks_ext - counter_ff;
   assign rest_m1    = rest - 16'd1;
   assign in_range   = (address >= rit_pkg::ADDR_RELOAD_LO) &&
                       (address <= rit_pkg::ADDR_CONTROL);

   // Take a request only when idle and the response slot is free or draining
   assign req_tready = (state_ff == rit_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   rit_mod #(
      .DW (TICK_BITS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (rest_m1[TICK_BITS-1:0]),
      .divisor   (reload_ff),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   // Sequencer and register file
   always_comb begin
      state_in      = state_ff;
      reload_in     = reload_ff;
      counter_in    = counter_ff;
      enabled_in    = enabled_ff;
      irq_in        = irq_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      div_ctl.start = 1'b0;
      hit           = 1'b0;
      rd            = 8'h00;

      case (state_ff)
         rit_pkg::ST_IDLE: begin
            if (accept) begin
               case (opcode)
                  rit_pkg::OP_READ: begin
                     if (in_range) begin
                        hit = 1'b1;
                        if (address == rit_pkg::ADDR_RELOAD_LO) begin
                           rd = reload_ff[7:0];
                        end else if (address == rit_pkg::ADDR_RELOAD_HI) begin
                           rd = reload_ff[15:8];
                        end else begin
                           rd = (irq_ff ? rit_pkg::STAT_IRQ : 8'h00) |
                                (enabled_ff ? rit_pkg::STAT_ACTIVE : 8'h00);
                           irq_in = 1'b0;
                        end
                     end
                  end
                  rit_pkg::OP_WRITE: begin
                     if (in_range) begin
                        hit = 1'b1;
                        if (address == rit_pkg::ADDR_RELOAD_LO) begin
                           reload_in = {reload_ff[15:8], write_data};
                        end else if (address == rit_pkg::ADDR_RELOAD_HI) begin
                           reload_in = {write_data, reload_ff[7:0]};
                        end else begin
                           if (!enabled_ff) begin
                              counter_in = reload_ff;
                           end
                           enabled_in = write_data[0];
                        end
                     end
                  end
                  rit_pkg::OP_CLOCK: begin
                     if (!enabled_ff) begin
                        counter_in = reload_ff;
                     end else if (ticks_ext <= counter_ff) begin
                        counter_in = counter_ff - ticks_ext;
                     end else begin
                        irq_in = 1'b1;
                        if (reload_ff == 16'h0000) begin
                           counter_in = 16'h0000;
                        end else begin
                           div_ctl.start = 1'b1;
                           state_in      = rit_pkg::ST_DIVIDE;
                        end
                     end
                  end
                  default: begin
                  end
               endcase

               // Post the response unless the wrap is still being worked out
               if (!div_ctl.start) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {6'b000000, irq_in, rd, hit};
               end
            end
         end
         rit_pkg::ST_DIVIDE: begin
            // Land the wrapped count once the remainder is ready
            if (div_stat.done) begin
               counter_in   = reload_ff - div_rem - 16'd1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b000000, irq_ff, 8'h00, 1'b0};
               state_in     = rit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rit_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rit_pkg::ST_IDLE;
         reload_ff    <= rit_pkg::RELOAD_RESET;
         counter_ff   <= rit_pkg::RELOAD_RESET;
         enabled_ff   <= 1'b0;
         irq_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reload_ff    <= reload_in;
         counter_ff   <= counter_in;
         enabled_ff   <= enabled_in;
         irq_ff       <= irq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // No request is taken while the remainder unit works
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rit_pkg::ST_DIVIDE) |-> !req_tready)
      else $error("request accepted during wrap computation");

   // The remainder unit only finishes while the sequencer waits for it
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == rit_pkg::ST_DIVIDE))
      else $error("remainder done outside of divide state");

   // The remainder unit only iterates while the sequencer waits for it
   a_busy_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == rit_pkg::ST_DIVIDE))
      else $error("remainder busy outside of divide state");

   // A wrap leaves the count below the reload value with irq raised
   a_wrap_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rit_pkg::ST_DIVIDE && div_stat.done) |=>
         (counter_ff < reload_ff) && irq_ff && rsp_valid_ff)
      else $error("wrapped count out of range");
`endif

endmodule

`default_nettype wire

// ----- tb/reload_irq_timer_test.sv -----
`default_nettype none

// Tracks the timer state from accepted requests and checks every response.
class irq_timer_checker;

   typedef struct {
      logic       hit;
      logic [7:0] read_data;
      logic       irq_line;
   } timer_response_type;

   logic [15:0]        reload_value;
   logic [15:0]        count;
   bit                 active;
   bit                 irq_pending;
   timer_response_type expected_responses[$];
   int                 error_count;

   function new();
      reload_value = rit_pkg::RELOAD_RESET;
      count        = rit_pkg::RELOAD_RESET;
      active       = 1'b0;
      irq_pending  = 1'b0;
      error_count  = 0;
   endfunction

   function int pending();
      return expected_responses.size();
   endfunction

   // Advance the down-counter, wrapping through the reload value on expiry
   function void run_ticks(logic [7:0] ticks);
      int unsigned excess;
      if (!active) begin
         count = reload_value;
         return;
      end
      if (ticks <= count) begin
         count = count - 16'(ticks);
         return;
      end
      irq_pending = 1'b1;
      excess = ticks - count;
      if (reload_value == 16'h0000) begin
         count = 16'h0000;
         return;
      end
      excess = ((excess - 1) % reload_value) + 1;
      count  = 16'(reload_value - excess);
   endfunction

   // Update state for one accepted request and queue its response
   function void note_request(logic [1:0] op, logic [15:0] addr, logic [7:0] wdata,
                              logic [7:0] ticks);
      timer_response_type rsp;
      bit                 in_range;
      in_range      = (addr >= rit_pkg::ADDR_RELOAD_LO) && (addr <= rit_pkg::ADDR_CONTROL);
      rsp.hit       = 1'b0;
      rsp.read_data = 8'h00;
      if (op == rit_pkg::OP_READ && in_range) begin
         rsp.hit = 1'b1;
         if (addr == rit_pkg::ADDR_RELOAD_LO) begin
            rsp.read_data = reload_value[7:0];
         end else if (addr == rit_pkg::ADDR_RELOAD_HI) begin
            rsp.read_data = reload_value[15:8];
         end else begin
            rsp.read_data = (irq_pending ? rit_pkg::STAT_IRQ : 8'h00) |
                            (active ? rit_pkg::STAT_ACTIVE : 8'h00);
            irq_pending = 1'b0;
         end
      end else if (op == rit_pkg::OP_WRITE && in_range) begin
         rsp.hit = 1'b1;
         if (addr == rit_pkg::ADDR_RELOAD_LO) begin
            reload_value[7:0] = wdata;
         end else if (addr == rit_pkg::ADDR_RELOAD_HI) begin
            reload_value[15:8] = wdata;
         end else begin
            if (!active) count = reload_value;
            active = wdata[0];
         end
      end else if (op == rit_pkg::OP_CLOCK) begin
         run_ticks(ticks);
      end
      rsp.irq_line = irq_pending;
      expected_responses.push_back(rsp);
   endfunction

   task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Compare one response against the oldest expectation
   task check_response(logic [15:0] tdata);
      timer_response_type want;
      if (expected_responses.size() == 0) begin
         report_mismatch($sformatf("unexpected response %h", tdata));
         return;
      end
      want = expected_responses.pop_front();
      if (tdata[0] !== want.hit)
         report_mismatch($sformatf("hit %b, expected %b", tdata[0], want.hit));
      if (tdata[8:1] !== want.read_data)
         report_mismatch($sformatf("read_data %h, expected %h", tdata[8:1], want.read_data));
      if (tdata[9] !== want.irq_line)
         report_mismatch($sformatf("irq_line %b, expected %b", tdata[9], want.irq_line));
   endtask

endclass

module reload_irq_timer_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_PER_PHASE  = 667;
   localparam int SETTLE_CYCLES     = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   irq_timer_checker timer_sb = new();

   reload_irq_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Throttle the response side
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Observe both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            timer_sb.note_request(req_tuser, req_tdata[15:0], req_tdata[23:16],
                                  req_tdata[31:24]);
         if (rsp_tvalid && rsp_tready) timer_sb.check_response(rsp_tdata);
      end
   end

   // Present one request transaction and hold it until accepted
   task send_item(logic [1:0] op, logic [15:0] addr, logic [7:0] wdata, logic [7:0] ticks);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {ticks, wdata, addr};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid and hold off until every queued response has come back
   task wait_for_responses();
      req_tvalid <= 1'b0;
      while (timer_sb.pending() != 0) @(negedge clock);
   endtask

   // Mostly programming, enabling, clocking and status polling; some noise
   task send_random_item();
      int          pick;
      logic [1:0]  op;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic [7:0]  ticks;
      pick  = $urandom_range(0, 99);
      addr  = 16'($urandom);
      wdata = 8'($urandom);
      ticks = 8'($urandom);
      if (pick < 40) begin
         op = rit_pkg::OP_CLOCK;
         if ($urandom_range(0, 1) == 0) ticks = 8'($urandom_range(0, 40));
      end else if (pick < 55) begin
         op   = rit_pkg::OP_READ;
         addr = rit_pkg::ADDR_RELOAD_LO + 16'($urandom_range(0, 2));
      end else if (pick < 70) begin
         op = rit_pkg::OP_WRITE;
         if ($urandom_range(0, 1) == 0) begin
            addr = rit_pkg::ADDR_RELOAD_LO;
            if ($urandom_range(0, 9) == 0) wdata = 8'h00;
         end else begin
            addr = rit_pkg::ADDR_RELOAD_HI;
            if ($urandom_range(0, 9) < 7) wdata = 8'($urandom_range(0, 1));
         end
      end else if (pick < 80) begin
         op       = rit_pkg::OP_WRITE;
         addr     = rit_pkg::ADDR_CONTROL;
         wdata[0] = ($urandom_range(0, 3) != 0);
      end else if (pick < 90) begin
         op   = rit_pkg::OP_READ;
         addr = rit_pkg::ADDR_CONTROL;
      end else begin
         op = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 3) == 0)
            addr = ($urandom_range(0, 1) == 0) ? rit_pkg::ADDR_RELOAD_LO - 16'd1
                                               : rit_pkg::ADDR_CONTROL + 16'd1;
      end
      send_item(op, addr, wdata, ticks);
   endtask

   // Register extremes, misses, expiry corner cases and the unused opcode
   task run_directed();
      send_item(rit_pkg::OP_READ,  rit_pkg::ADDR_RELOAD_LO, 8'h00, 8'h00);
      send_item(rit_pkg::OP_READ,  rit_pkg::ADDR_RELOAD_HI, 8'h00, 8'h00);
      send_item(rit_pkg::OP_READ,  rit_pkg::ADDR_CONTROL,   8'h00, 8'h00);
      send_item(rit_pkg::OP_CLOCK, 16'h0000,                8'h00, 8'h05);
      send_item(rit_pkg::OP_READ,  rit_pkg::ADDR_RELOAD_LO - 16'd1, 8'h00, 8'h00);
      send_item(rit_pkg::OP_WRITE, rit_pkg::ADDR_CONTROL + 16'd1,   8'hFF, 8'h00);
      send_item(rit_pkg::OP_READ,  16'h0000,                8'h00, 8'h00);
      send_item(rit_pkg::OP_WRITE, 16'hFFFF,                8'hAA, 8'hFF);
      send_item(OP_UNUSED,         rit_pkg::ADDR_CONTROL,   8'hFF, 8'hFF);
      send_item(rit_pkg::OP_WRITE, rit_pkg::ADDR_RELOAD_LO, 8'h10, 8'h00);
      send_item(rit_pkg::OP_WRITE, rit_pkg::ADDR_RELOAD_HI, 8'h00, 8'h00);
      send_item(rit_pkg::OP_WRITE, rit_pkg::ADDR_CONTROL,   8'h01, 8'h00);
      // counter runs out exactly, then one more tick expires it
      send_item(rit_pkg::OP_CLOCK, 16'h0000,                8'h00, 8'h10);
      send_item(rit_pkg::OP_CLOCK, 16'h0000,                8'h00, 8'h00);
      send_item(rit_pkg::OP_CLOCK, 16'h0000,                8'h00, 8'h01);
      send_item(rit_pkg::OP_READ,  rit_pkg::ADDR_CONTROL,   8'h00, 8'h00);
      send_item(rit_pkg::OP_CLOCK, 16'h0000,                8'h00, 8'hFF);
      send_item(rit_pkg::OP_WRITE, rit_pkg::ADDR_CONTROL,   8'h01, 8'h00);
      // zero reload keeps the counter at zero
      send_item(rit_pkg::OP_WRITE, rit_pkg::ADDR_RELOAD_LO, 8'h00, 8'h00);
      send_item(rit_pkg::OP_CLOCK, 16'h0000,                8'h00, 8'hC8);
      send_item(rit_pkg::OP_READ,  rit_pkg::ADDR_CONTROL,   8'h00, 8'h00);
      send_item(rit_pkg::OP_WRITE, rit_pkg::ADDR_CONTROL,   8'hFE, 8'h00);
      send_item(rit_pkg::OP_WRITE, rit_pkg::ADDR_RELOAD_HI, 8'hFF, 8'h00);
      send_item(rit_pkg::OP_WRITE, rit_pkg::ADDR_RELOAD_LO, 8'hFF, 8'h00);
      send_item(rit_pkg::OP_CLOCK, 16'h0000,                8'h00, 8'h03);
      send_item(rit_pkg::OP_READ,  rit_pkg::ADDR_RELOAD_HI, 8'h00, 8'h00);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 22;
      recv_idle_pct = 80;
      run_directed();
      wait_for_responses();

      // three idle profiles, draining fully between them
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 22; recv_idle_pct = 80; end
            1: begin send_idle_pct = 80; recv_idle_pct = 22; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         repeat (RANDOM_PER_PHASE) send_random_item();
         wait_for_responses();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (timer_sb.error_count == 0 && timer_sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
